// File: src/sat_pkg.sv
// Shared constants and controller/datapath interface types for the separating-axis test.
package sat_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int IDX_W        = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int COORD_W      = 16;
  localparam int VERT_W       = 2 * COORD_W;
  localparam int NORM_W       = COORD_W + 1;
  localparam int PROD_W       = NORM_W + COORD_W;
  localparam int PROJ_W       = PROD_W + 1;
  localparam int AXIS_IDX_W   = 4;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic             load;     // store the incoming vertex
    logic             clear;    // drop both polygons after a test
    logic             cap_a;    // read data holds the edge start vertex
    logic             cap_b;    // read data holds the edge end vertex
    logic             issue;    // projection read issued this cycle
    logic             in1;      // first polygon entry is valid
    logic             in2;      // second polygon entry is valid
    logic             first;    // first entry of the sweep
    logic [IDX_W-1:0] addr1;
    logic [IDX_W-1:0] addr2;
  } sat_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [CNT_W-1:0] n1;
    logic [CNT_W-1:0] n2;
    logic             ovf;
    logic             pipe_busy;
    logic             sep;
  } sat_stat_t;

endpackage

// File: src/sat_datapath.sv
// Vertex stores, edge normal, projection pipeline and interval tracking.
module sat_datapath import sat_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  sat_cmd_t                  cmd_i,
  input  logic                      func_i,
  input  logic signed [COORD_W-1:0] vertex_x_i,
  input  logic signed [COORD_W-1:0] vertex_y_i,
  output sat_stat_t                 stat_o
);

  typedef struct packed {
    logic v;
    logic in1;
    logic in2;
    logic first;
  } tag_t;

  logic [VERT_W-1:0] first_mem  [MAX_VERTICES];
  logic [VERT_W-1:0] second_mem [MAX_VERTICES];
  logic [VERT_W-1:0] rdata1_q, rdata2_q;

  logic [CNT_W-1:0] n1_q, n2_q;
  logic             ovf_q;

  logic signed [COORD_W-1:0] ex_q, ey_q;
  logic signed [NORM_W-1:0]  ax_q, ay_q;
  logic signed [NORM_W-1:0]  ax_d, ay_d;

  tag_t tag1_q, tag2_q, tag3_q;
  logic signed [PROD_W-1:0] px1_q, py1_q, px2_q, py2_q;
  logic signed [PROJ_W-1:0] p1_q, p2_q;
  logic signed [PROJ_W-1:0] lo1_q, hi1_q, lo2_q, hi2_q;

  logic signed [COORD_W-1:0] x1, y1, x2, y2;
  logic                      room1, room2;

  assign room1 = n1_q < CNT_W'(MAX_VERTICES);
  assign room2 = n2_q < CNT_W'(MAX_VERTICES);

  // Vertex memories, one write and one registered read each
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && !func_i && room1) begin
      first_mem[n1_q[IDX_W-1:0]] <= {vertex_y_i, vertex_x_i};
    end
    if (cmd_i.load && func_i && room2) begin
      second_mem[n2_q[IDX_W-1:0]] <= {vertex_y_i, vertex_x_i};
    end
    rdata1_q <= first_mem[cmd_i.addr1];
    rdata2_q <= second_mem[cmd_i.addr2];
  end

  // Fill counts and overflow flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n1_q  <= '0;
      n2_q  <= '0;
      ovf_q <= 1'b0;
    end else if (cmd_i.clear) begin
      n1_q  <= '0;
      n2_q  <= '0;
      ovf_q <= 1'b0;
    end else if (cmd_i.load) begin
      if (!func_i) begin
        if (room1) n1_q <= n1_q + CNT_W'(1);
        else       ovf_q <= 1'b1;
      end else begin
        if (room2) n2_q <= n2_q + CNT_W'(1);
        else       ovf_q <= 1'b1;
      end
    end
  end

  assign x1 = rdata1_q[COORD_W-1:0];
  assign y1 = rdata1_q[VERT_W-1:COORD_W];
  assign x2 = rdata2_q[COORD_W-1:0];
  assign y2 = rdata2_q[VERT_W-1:COORD_W];

  // Edge normal (-dy, dx), left unnormalized
  assign ax_d = NORM_W'(ey_q) - NORM_W'(y1);
  assign ay_d = NORM_W'(x1) - NORM_W'(ex_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_a) begin
      ex_q <= x1;
      ey_q <= y1;
    end
    if (cmd_i.cap_b) begin
      ax_q <= ax_d;
      ay_q <= ay_d;
    end
  end

  // Projection pipeline tags: read, multiply, add
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
      tag3_q <= '0;
    end else begin
      tag1_q <= '{v: cmd_i.issue, in1: cmd_i.in1, in2: cmd_i.in2, first: cmd_i.first};
      tag2_q <= tag1_q;
      tag3_q <= tag2_q;
    end
  end

  // Multiply stage then add stage
  always_ff @(posedge clk_i) begin
    px1_q <= PROD_W'(ax_q) * PROD_W'(x1);
    py1_q <= PROD_W'(ay_q) * PROD_W'(y1);
    px2_q <= PROD_W'(ax_q) * PROD_W'(x2);
    py2_q <= PROD_W'(ay_q) * PROD_W'(y2);
    p1_q  <= PROJ_W'(px1_q) + PROJ_W'(py1_q);
    p2_q  <= PROJ_W'(px2_q) + PROJ_W'(py2_q);
  end

  // Running interval of each polygon on the current axis
  always_ff @(posedge clk_i) begin
    if (tag3_q.v && tag3_q.in1) begin
      if (tag3_q.first || p1_q < lo1_q) lo1_q <= p1_q;
      if (tag3_q.first || p1_q > hi1_q) hi1_q <= p1_q;
    end
    if (tag3_q.v && tag3_q.in2) begin
      if (tag3_q.first || p2_q < lo2_q) lo2_q <= p2_q;
      if (tag3_q.first || p2_q > hi2_q) hi2_q <= p2_q;
    end
  end

  assign stat_o.n1        = n1_q;
  assign stat_o.n2        = n2_q;
  assign stat_o.ovf       = ovf_q;
  assign stat_o.pipe_busy = tag1_q.v | tag2_q.v | tag3_q.v;
  assign stat_o.sep       = (lo1_q >= hi2_q) || (lo2_q >= hi1_q);

endmodule

// File: src/sat_controller.sv
// Sequencer over edges of the first polygon and vertex sweeps, with result registers.
module sat_controller import sat_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  func_i,
  input  logic                  last_vertex_i,
  input  sat_stat_t             stat_i,
  output sat_cmd_t              cmd_o,
  output logic                  busy_o,
  output logic                  done_o,
  output logic                  separated_o,
  output logic [AXIS_IDX_W-1:0] axis_index_o,
  output logic [1:0]            status_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_EDGE_A,
    S_EDGE_B,
    S_EDGE_C,
    S_PROJ,
    S_DRAIN
  } state_e;

  state_e                 state_q;
  logic [IDX_W-1:0]       i_q, k_q;
  logic                   done_q, sep_q;
  logic [AXIS_IDX_W-1:0]  idx_q;
  status_e                status_q;

  logic [CNT_W-1:0] i_next, k_next, k_max;
  logic [IDX_W-1:0] j;
  logic             finish;
  status_e          run_status;

  assign i_next     = CNT_W'(i_q) + CNT_W'(1);
  assign k_next     = CNT_W'(k_q) + CNT_W'(1);
  assign k_max      = (stat_i.n1 > stat_i.n2) ? stat_i.n1 : stat_i.n2;
  assign j          = (i_next < stat_i.n1) ? i_next[IDX_W-1:0] : '0;
  assign run_status = stat_i.ovf ? ST_OVERFLOW : ST_OK;

  // A test ends on an empty polygon, a separating axis, or the last edge
  always_comb begin
    finish = 1'b0;
    case (state_q)
      S_CHECK: finish = (stat_i.n1 == '0) || (stat_i.n2 == '0);
      S_DRAIN: finish = !stat_i.pipe_busy && (stat_i.sep || i_next == stat_i.n1);
      default: finish = 1'b0;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd_o       = '0;
    cmd_o.load  = start_i && (state_q == S_IDLE);
    cmd_o.clear = finish;
    case (state_q)
      S_EDGE_A: cmd_o.addr1 = i_q;
      S_EDGE_B: begin
        cmd_o.addr1 = j;
        cmd_o.cap_a = 1'b1;
      end
      S_EDGE_C: cmd_o.cap_b = 1'b1;
      S_PROJ: begin
        cmd_o.addr1 = k_q;
        cmd_o.addr2 = k_q;
        cmd_o.issue = 1'b1;
        cmd_o.in1   = CNT_W'(k_q) < stat_i.n1;
        cmd_o.in2   = CNT_W'(k_q) < stat_i.n2;
        cmd_o.first = (k_q == '0);
      end
      default: ;
    endcase
  end

  // State and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      i_q      <= '0;
      k_q      <= '0;
      done_q   <= 1'b0;
      sep_q    <= 1'b0;
      idx_q    <= '0;
      status_q <= ST_OK;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start_i && func_i && last_vertex_i) state_q <= S_CHECK;
        end
        S_CHECK: begin
          i_q <= '0;
          if (finish) begin
            done_q   <= 1'b1;
            sep_q    <= 1'b0;
            idx_q    <= '0;
            status_q <= ST_EMPTY;
            state_q  <= S_IDLE;
          end else begin
            state_q <= S_EDGE_A;
          end
        end
        S_EDGE_A: state_q <= S_EDGE_B;
        S_EDGE_B: state_q <= S_EDGE_C;
        S_EDGE_C: begin
          k_q     <= '0;
          state_q <= S_PROJ;
        end
        S_PROJ: begin
          k_q <= k_next[IDX_W-1:0];
          if (k_next == k_max) state_q <= S_DRAIN;
        end
        S_DRAIN: begin
          if (finish) begin
            done_q   <= 1'b1;
            sep_q    <= stat_i.sep;
            idx_q    <= stat_i.sep ? AXIS_IDX_W'(i_q) : '0;
            status_q <= run_status;
            state_q  <= S_IDLE;
          end else if (!stat_i.pipe_busy) begin
            i_q     <= i_next[IDX_W-1:0];
            state_q <= S_EDGE_A;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o       = (state_q != S_IDLE);
  assign done_o       = done_q;
  assign separated_o  = sep_q;
  assign axis_index_o = idx_q;
  assign status_o     = status_q;

endmodule

// File: src/polygon_separating_axis_test.sv
// A second-polygon vertex marked last starts the test. For each edge of the first polygon,
// at most n1 of them where n1 is the first polygon's vertex count, the block reads the edge,
// issues K projection reads over both vertex memories, K being the larger count, and drains
// the pipeline; done_o pulses once the test ends.
// busy_o stays high during the test; done_o is a one-cycle strobe the receiver cannot stall.
// Reset clears counts, overflow flag and controller; vertex memories are not cleared.
module polygon_separating_axis_test import sat_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic                      func_i,
  input  logic signed [COORD_W-1:0] vertex_x_i,
  input  logic signed [COORD_W-1:0] vertex_y_i,
  input  logic                      last_vertex_i,
  output logic                      done_o,
  output logic                      separated_o,
  output logic [AXIS_IDX_W-1:0]     axis_index_o,
  output logic [1:0]                status_o
);

  sat_cmd_t  cmd;
  sat_stat_t stat;

  sat_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .func_i     (func_i),
    .vertex_x_i (vertex_x_i),
    .vertex_y_i (vertex_y_i),
    .stat_o     (stat)
  );

  sat_controller u_controller (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .func_i        (func_i),
    .last_vertex_i (last_vertex_i),
    .stat_i        (stat),
    .cmd_o         (cmd),
    .busy_o        (busy_o),
    .done_o        (done_o),
    .separated_o   (separated_o),
    .axis_index_o  (axis_index_o),
    .status_o      (status_o)
  );

endmodule

// File: src/sat_checker.sv
// Port-level checks on the separating-axis test, bound to the top level.
module sat_checker import sat_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  start_i,
  input logic                  busy_o,
  input logic                  func_i,
  input logic                  last_vertex_i,
  input logic                  done_o,
  input logic                  separated_o,
  input logic [AXIS_IDX_W-1:0] axis_index_o,
  input logic [1:0]            status_o
);

  // A test transaction always occupies the block
  a_test_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && func_i && last_vertex_i |=> busy_o)
    else $error("test did not start");

  // Results only end a busy period
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o && $past(busy_o))
    else $error("result without a running test");

  // No separating axis means axis index zero
  a_idx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !separated_o |-> axis_index_o == '0)
    else $error("axis index set without separation");

  // Empty polygon never reports separation
  a_empty_not_sep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o == ST_EMPTY |-> !separated_o)
    else $error("separation reported for empty polygon");

  // Status code stays within its defined values
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> status_o == ST_OK || status_o == ST_EMPTY || status_o == ST_OVERFLOW)
    else $error("undefined status code");

endmodule

bind polygon_separating_axis_test sat_checker u_sat_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_o        (busy_o),
  .func_i        (func_i),
  .last_vertex_i (last_vertex_i),
  .done_o        (done_o),
  .separated_o   (separated_o),
  .axis_index_o  (axis_index_o),
  .status_o      (status_o)
);

// File: test/tb_polygon_separating_axis_test.sv
// Self-checking testbench for the polygon separating-axis test block.
module tb_polygon_separating_axis_test;
  import sat_pkg::*;

  localparam int          TOTAL_VERTICES = 1700;
  localparam int unsigned LIMIT_CYCLES   = 4_000_000;
  // Extra wait after the last verdict, sized for the worst test plus margin
  localparam int          DRAIN_CYCLES   = 400;

  typedef struct packed {
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } vertex_t;

  typedef struct {
    logic                  which;
    vertex_t               pt;
    logic                  last;
  } vertex_item_t;

  typedef struct {
    logic                  separated;
    logic [AXIS_IDX_W-1:0] axis_index;
    status_e               status;
  } sat_verdict_t;

  // Tracks both polygons as the block should hold them and queues the verdict due
  // for every test that an accepted vertex starts.
  class separation_scoreboard;
    vertex_t        first_pts[MAX_VERTICES];
    vertex_t        second_pts[MAX_VERTICES];
    int unsigned    n_first;
    int unsigned    n_second;
    bit             dropped_vertex;
    sat_verdict_t   verdicts_due[$];
    int unsigned    mismatches;

    function new();
      n_first        = 0;
      n_second       = 0;
      dropped_vertex = 0;
      mismatches     = 0;
    endfunction

    // min/max of all projections onto the axis (ax, ay)
    function void project_span(input vertex_t pts[MAX_VERTICES], input int unsigned n,
                               input longint ax, input longint ay,
                               output longint lo, output longint hi);
      longint p;
      lo = ax * longint'(pts[0].x) + ay * longint'(pts[0].y);
      hi = lo;
      for (int unsigned k = 1; k < n; k++) begin
        p = ax * longint'(pts[k].x) + ay * longint'(pts[k].y);
        if (p < lo) lo = p;
        if (p > hi) hi = p;
      end
    endfunction

    // Try each edge normal of the first polygon in order; first separating one wins
    function sat_verdict_t sweep_axes();
      sat_verdict_t v;
      int unsigned  j;
      longint       dx, dy, lo1, hi1, lo2, hi2;
      bit           found;
      v.separated  = 1'b0;
      v.axis_index = '0;
      found        = 0;
      if (n_first == 0 || n_second == 0) begin
        v.status = ST_EMPTY;
      end else begin
        v.status = dropped_vertex ? ST_OVERFLOW : ST_OK;
        for (int unsigned i = 0; i < n_first && !found; i++) begin
          j  = (i + 1 < n_first) ? i + 1 : 0;
          dx = longint'(first_pts[j].x) - longint'(first_pts[i].x);
          dy = longint'(first_pts[j].y) - longint'(first_pts[i].y);
          project_span(first_pts, n_first, -dy, dx, lo1, hi1);
          project_span(second_pts, n_second, -dy, dx, lo2, hi2);
          if (lo1 >= hi2 || lo2 >= hi1) begin
            found        = 1;
            v.separated  = 1'b1;
            v.axis_index = AXIS_IDX_W'(i);
          end
        end
      end
      return v;
    endfunction

    function void note_vertex(input logic which, input vertex_t pt, input logic last);
      if (which == 1'b0) begin
        if (n_first < MAX_VERTICES) first_pts[n_first++] = pt;
        else dropped_vertex = 1;
        return;
      end
      if (n_second < MAX_VERTICES) second_pts[n_second++] = pt;
      else dropped_vertex = 1;
      if (last) begin
        verdicts_due.push_back(sweep_axes());
        n_first        = 0;
        n_second       = 0;
        dropped_vertex = 0;
      end
    endfunction

    function void check_verdict(input logic sep, input logic [AXIS_IDX_W-1:0] axis,
                                input logic [1:0] status);
      sat_verdict_t e;
      if (verdicts_due.size() == 0) begin
        $display("%0t: unexpected result sep=%0d axis=%0d status=%0d",
                 $time, sep, axis, status);
        mismatches++;
        return;
      end
      e = verdicts_due.pop_front();
      if (sep !== e.separated) begin
        $display("%0t: separated mismatch: expected %0d actual %0d", $time, e.separated, sep);
        mismatches++;
      end
      if (axis !== e.axis_index) begin
        $display("%0t: axis_index mismatch: expected %0d actual %0d",
                 $time, e.axis_index, axis);
        mismatches++;
      end
      if (status !== e.status) begin
        $display("%0t: status mismatch: expected %0d actual %0d", $time, e.status, status);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return verdicts_due.size();
    endfunction
  endclass

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      start_i = 1'b0;
  logic                      func_i = 1'b0;
  logic signed [COORD_W-1:0] vertex_x_i = '0;
  logic signed [COORD_W-1:0] vertex_y_i = '0;
  logic                      last_vertex_i = 1'b0;
  logic                      busy_o;
  logic                      done_o;
  logic                      separated_o;
  logic [AXIS_IDX_W-1:0]     axis_index_o;
  logic [1:0]                status_o;

  separation_scoreboard sb;
  int unsigned          vertices_sent = 0;
  int unsigned          cycle_count = 0;

  polygon_separating_axis_test DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .func_i        (func_i),
    .vertex_x_i    (vertex_x_i),
    .vertex_y_i    (vertex_y_i),
    .last_vertex_i (last_vertex_i),
    .done_o        (done_o),
    .separated_o   (separated_o),
    .axis_index_o  (axis_index_o),
    .status_o      (status_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Monitor: results first, then the accepted vertex transaction of the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) sb.check_verdict(separated_o, axis_index_o, status_o);
      if (start_i && !busy_o) sb.note_vertex(func_i, {vertex_y_i, vertex_x_i}, last_vertex_i);
    end
  end

  function automatic logic signed [COORD_W-1:0] sat16(input int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return COORD_W'(v);
  endfunction

  function automatic vertex_t pick_point(input int cx, input int cy, input int r,
                                         input bit wide);
    vertex_t p;
    if (wide) begin
      p.x = COORD_W'($urandom);
      p.y = COORD_W'($urandom);
    end else begin
      p.x = sat16(cx + int'($urandom_range(0, 2 * r)) - r);
      p.y = sat16(cy + int'($urandom_range(0, 2 * r)) - r);
    end
    return p;
  endfunction

  // Mostly small polygons, a few near-full ones, a few that overflow, and optionally empty ones
  function automatic int pick_count(input bit allow_empty);
    int roll;
    roll = $urandom_range(0, 99);
    if (allow_empty && roll < 4) return 0;
    if (roll < 70) return $urandom_range(1, 5);
    if (roll < 88) return $urandom_range(6, 12);
    if (roll < 95) return $urandom_range(13, MAX_VERTICES);
    return $urandom_range(MAX_VERTICES + 1, MAX_VERTICES + 3);
  endfunction

  // One vertex transaction; start stays high until accepted
  task automatic drive_vertex(input logic which, input logic signed [COORD_W-1:0] x,
                              input logic signed [COORD_W-1:0] y, input logic last);
    bit gaps_on;
    gaps_on = !(vertices_sent >= 700 && vertices_sent < 1100);
    if (gaps_on && $urandom_range(0, 99) < 6) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i       <= 1'b1;
    func_i        <= which;
    vertex_x_i    <= x;
    vertex_y_i    <= y;
    last_vertex_i <= last;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    vertices_sent++;
  endtask

  task automatic send_directed();
    // empty first polygon
    drive_vertex(1'b1, 16'sd0, 16'sd0, 1'b1);
    // single-vertex first polygon, last flag on it, opposite extremes
    drive_vertex(1'b0, -16'sd32768, -16'sd32768, 1'b1);
    drive_vertex(1'b1, 16'sd32767, 16'sd32767, 1'b1);
    // extreme triangle against a single corner point
    drive_vertex(1'b0, -16'sd32768, -16'sd32768, 1'b0);
    drive_vertex(1'b0, 16'sd32767, -16'sd32768, 1'b0);
    drive_vertex(1'b0, -16'sd32768, 16'sd32767, 1'b0);
    drive_vertex(1'b1, 16'sd32767, 16'sd32767, 1'b1);
    // overlapping squares
    drive_vertex(1'b0, 16'sd0, 16'sd0, 1'b0);
    drive_vertex(1'b0, 16'sd100, 16'sd0, 1'b0);
    drive_vertex(1'b0, 16'sd100, 16'sd100, 1'b0);
    drive_vertex(1'b0, 16'sd0, 16'sd100, 1'b0);
    drive_vertex(1'b1, 16'sd50, 16'sd50, 1'b0);
    drive_vertex(1'b1, 16'sd150, 16'sd50, 1'b0);
    drive_vertex(1'b1, 16'sd150, 16'sd150, 1'b0);
    drive_vertex(1'b1, 16'sd50, 16'sd150, 1'b1);
    // square and triangle meeting at a corner: intervals touch
    drive_vertex(1'b0, 16'sd0, 16'sd0, 1'b0);
    drive_vertex(1'b0, 16'sd10, 16'sd0, 1'b0);
    drive_vertex(1'b0, 16'sd10, 16'sd10, 1'b0);
    drive_vertex(1'b0, 16'sd0, 16'sd10, 1'b0);
    drive_vertex(1'b1, 16'sd10, 16'sd0, 1'b0);
    drive_vertex(1'b1, 16'sd20, 16'sd0, 1'b0);
    drive_vertex(1'b1, 16'sd20, 16'sd10, 1'b1);
  endtask

  // One test: two point clouds at a random distance, optionally interleaved,
  // or a short burst of unstructured noise
  task automatic send_random_pair();
    vertex_item_t firsts[$];
    vertex_item_t seconds[$];
    vertex_item_t order[$];
    vertex_item_t it;
    vertex_item_t final_item;
    int           n1, n2, cx, cy, r, ox, oy, roll;
    bit           wide;
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      repeat ($urandom_range(1, 6))
        drive_vertex(1'($urandom_range(0, 1)), COORD_W'($urandom), COORD_W'($urandom),
                     1'($urandom_range(0, 1)));
      return;
    end
    n1   = pick_count(1'b1);
    n2   = pick_count(1'b0);
    wide = ($urandom_range(0, 99) < 10);
    case ($urandom_range(0, 2))
      0: r = $urandom_range(1, 16);
      1: r = $urandom_range(1, 500);
      default: r = $urandom_range(1, 32767);
    endcase
    cx = int'($urandom_range(0, 65535)) - 32768;
    cy = int'($urandom_range(0, 65535)) - 32768;
    ox = int'($urandom_range(0, 6 * r)) - 3 * r;
    oy = int'($urandom_range(0, 6 * r)) - 3 * r;
    for (int k = 0; k < n1; k++) begin
      it.which = 1'b0;
      it.pt    = pick_point(cx, cy, r, wide);
      it.last  = ($urandom_range(0, 99) < 10);
      firsts.push_back(it);
    end
    for (int k = 0; k < n2; k++) begin
      it.which = 1'b1;
      it.pt    = pick_point(cx + ox, cy + oy, r, wide);
      it.last  = 1'b0;
      seconds.push_back(it);
    end
    final_item      = seconds.pop_back();
    final_item.last = 1'b1;
    if ($urandom_range(0, 99) < 20) begin
      // interleave the two polygons
      while (firsts.size() != 0 || seconds.size() != 0) begin
        if (seconds.size() == 0 || (firsts.size() != 0 && $urandom_range(0, 1)))
          order.push_back(firsts.pop_front());
        else
          order.push_back(seconds.pop_front());
      end
    end else begin
      order = {firsts, seconds};
    end
    order.push_back(final_item);
    foreach (order[k]) drive_vertex(order[k].which, order[k].pt.x, order[k].pt.y,
                                    order[k].last);
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_directed();
    while (vertices_sent < TOTAL_VERTICES) send_random_pair();
    start_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
